/* src/tcw_pkg.sv */
// Package with the shared types and constants of the text console writer.
`timescale 1ns / 1ps
`default_nettype none
package tcw_pkg;
  localparam int unsigned ColumnsDefault = 80;
  localparam int unsigned RowsDefault = 25;
  localparam int unsigned IdxW = 11;
  localparam int unsigned ColW = 7;
  localparam int unsigned RowW = 5;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Classified command handed from the front part to the back part.
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_BS,
    CMD_TAB,
    CMD_NL,
    CMD_CR,
    CMD_PRINT,
    CMD_CLEAR,
    CMD_READ
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [7:0]      code;
    logic [IdxW-1:0] index;
  } cmd_t;

  // States of the back part sequencer.
  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_READ, S_SCR_RD, S_SCR_WR, S_FILL, S_DONE
  } state_e;

  localparam logic [2:0] RegTextFg = 3'd0;
  localparam logic [2:0] RegTextBg = 3'd1;
  localparam logic [2:0] RegBlankCode = 3'd2;
  localparam logic [2:0] RegBlankFg = 3'd3;
  localparam logic [2:0] RegBlankBg = 3'd4;
endpackage
`default_nettype wire

/* src/tcw_front.sv */
// Front part: accepts commands, classifies them and queues them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module tcw_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [1:0]                 op_i,
  input  wire logic [7:0]                 char_code_i,
  input  wire logic [tcw_pkg::IdxW-1:0]   cell_index_i,
  output logic                            accept_o,
  input  wire logic                       pop_i,
  output logic                            cmd_valid_o,
  output tcw_pkg::cmd_t                   cmd_o
);
  // Two-entry queue.
  tcw_pkg::cmd_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  tcw_pkg::cmd_t cls;

  always_comb begin
    cls.code = char_code_i;
    cls.index = cell_index_i;
    cls.cmd = tcw_pkg::CMD_NOP;
    case (op_i)
      tcw_pkg::OP_PUT: begin
        case (char_code_i)
          8'h08: cls.cmd = tcw_pkg::CMD_BS;
          8'h09: cls.cmd = tcw_pkg::CMD_TAB;
          8'h0A: cls.cmd = tcw_pkg::CMD_NL;
          8'h0D: cls.cmd = tcw_pkg::CMD_CR;
          default: begin
            if (char_code_i >= 8'h20 && char_code_i <= 8'h7F) cls.cmd = tcw_pkg::CMD_PRINT;
          end
        endcase
      end
      tcw_pkg::OP_CLEAR: cls.cmd = tcw_pkg::CMD_CLEAR;
      tcw_pkg::OP_READ:  cls.cmd = tcw_pkg::CMD_READ;
      default:           cls.cmd = tcw_pkg::CMD_NOP;
    endcase
  end

  logic push;
  assign accept_o = (cnt_q != 2'd2);
  assign push = start_i && accept_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= cls;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

/* src/tcw_back.sv */
// Back part: cursor logic, screen store, scroll and clear sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tcw_back #(
  parameter int unsigned Columns = tcw_pkg::ColumnsDefault,
  parameter int unsigned Rows = tcw_pkg::RowsDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cmd_valid_i,
  input  tcw_pkg::cmd_t                  cmd_i,
  output logic                           pop_o,
  output logic                           idle_o,
  input  wire logic [15:0]               text_cell_i,
  input  wire logic [15:0]               blank_cell_i,
  output logic                           done_o,
  output logic [tcw_pkg::ColW-1:0]       cursor_col_o,
  output logic [tcw_pkg::RowW-1:0]       cursor_row_o,
  output logic [tcw_pkg::IdxW-1:0]       cursor_pos_o,
  output logic                           scrolled_o,
  output logic [7:0]                     cell_code_o,
  output logic [3:0]                     cell_fg_o,
  output logic [3:0]                     cell_bg_o
);
  localparam int unsigned Cells = Columns * Rows;
  localparam int unsigned AW = $clog2(Cells);
  localparam logic [AW:0] CellsC = (AW+1)'(Cells);
  localparam logic [AW:0] ScrollEnd = (AW+1)'(Cells - Columns);
  localparam logic [AW:0] ColumnsA = (AW+1)'(Columns);

  tcw_pkg::state_e state_q, state_d;
  logic [15:0] mem [Cells];
  logic [15:0] rdata_q;
  logic [tcw_pkg::ColW-1:0] col_q, col_d;
  logic [tcw_pkg::RowW-1:0] row_q, row_d;
  logic [AW:0] ptr_q, ptr_d;
  logic        scr_q, scr_d, rd_q, rd_d;
  logic        we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]  wdata;
  logic [tcw_pkg::IdxW-1:0] pos_q, pos_d;
  logic [7:0]  ncol;
  logic [5:0]  nrow;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::S_INIT;
      col_q <= '0;
      row_q <= '0;
      pos_q <= '0;
      ptr_q <= '0;
      scr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q <= col_d;
      row_q <= row_d;
      pos_q <= pos_d;
      ptr_q <= ptr_d;
      scr_q <= scr_d;
      rd_q <= rd_d;
    end
  end

  always_comb begin
    state_d = state_q;
    col_d = col_q;
    row_d = row_q;
    pos_d = pos_q;
    ptr_d = ptr_q;
    scr_d = scr_q;
    rd_d = rd_q;
    we = 1'b0;
    re = 1'b0;
    waddr = ptr_q[AW-1:0];
    raddr = ptr_q[AW-1:0];
    wdata = blank_cell_i;
    pop_o = 1'b0;
    done_o = 1'b0;
    ncol = {1'b0, col_q};
    nrow = {1'b0, row_q};
    case (state_q)
      tcw_pkg::S_INIT: begin
        // Reset clearing pass: store reads as zero.
        we = 1'b1;
        wdata = '0;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CellsC - 1'b1) begin
          ptr_d = '0;
          state_d = tcw_pkg::S_IDLE;
        end
      end
      tcw_pkg::S_IDLE: begin
        scr_d = 1'b0;
        rd_d = 1'b0;
        if (cmd_valid_i) begin
          pop_o = 1'b1;
          state_d = tcw_pkg::S_DONE;
          case (cmd_i.cmd)
            tcw_pkg::CMD_BS: if (col_q != '0) ncol = {1'b0, col_q} - 8'd1;
            tcw_pkg::CMD_TAB: ncol = ({1'b0, col_q} + 8'd8) & 8'hF8;
            tcw_pkg::CMD_NL: begin
              ncol = '0;
              nrow = {1'b0, row_q} + 6'd1;
            end
            tcw_pkg::CMD_CR: ncol = '0;
            tcw_pkg::CMD_PRINT: begin
              we = 1'b1;
              waddr = pos_q[AW-1:0];
              wdata = text_cell_i;
              ncol = {1'b0, col_q} + 8'd1;
            end
            tcw_pkg::CMD_CLEAR: begin
              ncol = '0;
              nrow = '0;
              ptr_d = '0;
              state_d = tcw_pkg::S_FILL;
            end
            tcw_pkg::CMD_READ: begin
              rd_d = 1'b1;
              if ({1'b0, cmd_i.index} < 12'(Cells)) begin
                re = 1'b1;
                raddr = cmd_i.index[AW-1:0];
                state_d = tcw_pkg::S_READ;
              end else begin
                re = 1'b0;
                rd_d = 1'b0;
              end
            end
            default: ;
          endcase
          if (ncol >= 8'(Columns)) begin
            ncol = '0;
            nrow = nrow + 6'd1;
          end
          col_d = ncol[tcw_pkg::ColW-1:0];
          if (nrow >= 6'(Rows)) begin
            row_d = tcw_pkg::RowW'(Rows - 1);
            scr_d = 1'b1;
            ptr_d = '0;
            state_d = tcw_pkg::S_SCR_RD;
          end else begin
            row_d = nrow[tcw_pkg::RowW-1:0];
          end
          pos_d = tcw_pkg::IdxW'(32'(row_d) * Columns + 32'(col_d));
        end
      end
      tcw_pkg::S_READ: state_d = tcw_pkg::S_DONE;
      tcw_pkg::S_SCR_RD: begin
        re = 1'b1;
        raddr = AW'(ptr_q + ColumnsA);
        state_d = tcw_pkg::S_SCR_WR;
      end
      tcw_pkg::S_SCR_WR: begin
        we = 1'b1;
        wdata = rdata_q;
        ptr_d = ptr_q + 1'b1;
        state_d = (ptr_q + 1'b1 == ScrollEnd) ? tcw_pkg::S_FILL : tcw_pkg::S_SCR_RD;
      end
      tcw_pkg::S_FILL: begin
        we = 1'b1;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == CellsC - 1'b1) state_d = tcw_pkg::S_DONE;
      end
      tcw_pkg::S_DONE: begin
        done_o = 1'b1;
        state_d = tcw_pkg::S_IDLE;
      end
      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  assign idle_o = (state_q == tcw_pkg::S_IDLE);
  assign cursor_col_o = col_q;
  assign cursor_row_o = row_q;
  assign cursor_pos_o = pos_q;
  assign scrolled_o = scr_q;
  assign cell_code_o = rd_q ? rdata_q[7:0] : 8'd0;
  assign cell_fg_o = rd_q ? rdata_q[11:8] : 4'd0;
  assign cell_bg_o = rd_q ? rdata_q[15:12] : 4'd0;
endmodule
`default_nettype wire

/* src/text_console_char_writer_top.sv */
// Top level of the text console character writer.
`timescale 1ns / 1ps
`default_nettype none
// A command beat is taken when start is high and busy is low. Every command
// gives one result, shown for exactly one cycle with done_o high; the receiver
// cannot stall it. Only one command is in flight at a time. Control bytes,
// printable bytes, ignored bytes and out-of-range reads pass from the front
// queue through the idle state to the done state; an in-range read passes the
// read state on the way, since the screen store has a registered read port.
// A put that scrolls copies the store up one line at one cell per read and
// write pair and then blanks the bottom row before its result. A clear blanks
// one cell per cycle before its result. busy drops in the cycle after the
// result beat, so the next command can be taken from then on. After reset a
// clearing pass zeroes the store before the first command is carried out
// (one command is queued meanwhile). Configuration registers are written
// over the APB-style port; the user must write them only while the block is
// idle, which the block itself does not enforce.
module text_console_char_writer_top #(
  parameter int unsigned Columns = tcw_pkg::ColumnsDefault,
  parameter int unsigned Rows = tcw_pkg::RowsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  op_i,
  input  wire logic [7:0]  char_code_i,
  input  wire logic [10:0] cell_index_i,
  output logic             done_o,
  output logic [6:0]       cursor_col_o,
  output logic [4:0]       cursor_row_o,
  output logic [10:0]      cursor_pos_o,
  output logic             scrolled_o,
  output logic [7:0]       cell_code_o,
  output logic [3:0]       cell_fg_o,
  output logic [3:0]       cell_bg_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [3:0] text_fg_q, text_bg_q, blank_fg_q, blank_bg_q;
  logic [7:0] blank_code_q;
  logic       accept, pop, cmd_valid, idle;
  tcw_pkg::cmd_t cmd;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_fg_q <= 4'd15;
      text_bg_q <= 4'd0;
      blank_code_q <= 8'd32;
      blank_fg_q <= 4'd15;
      blank_bg_q <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        tcw_pkg::RegTextFg:    text_fg_q <= pwdata[3:0];
        tcw_pkg::RegTextBg:    text_bg_q <= pwdata[3:0];
        tcw_pkg::RegBlankCode: blank_code_q <= pwdata[7:0];
        tcw_pkg::RegBlankFg:   blank_fg_q <= pwdata[3:0];
        tcw_pkg::RegBlankBg:   blank_bg_q <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      tcw_pkg::RegTextFg:    prdata = {28'd0, text_fg_q};
      tcw_pkg::RegTextBg:    prdata = {28'd0, text_bg_q};
      tcw_pkg::RegBlankCode: prdata = {24'd0, blank_code_q};
      tcw_pkg::RegBlankFg:   prdata = {28'd0, blank_fg_q};
      tcw_pkg::RegBlankBg:   prdata = {28'd0, blank_bg_q};
      default:               prdata = '0;
    endcase
  end

  // One command at a time is in flight, so busy covers the front queue and
  // the back part until its result beat has gone out.
  logic inflight_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inflight_q <= 1'b0;
    else if (start && !busy) inflight_q <= 1'b1;
    else if (done_o) inflight_q <= 1'b0;
  end
  assign busy = inflight_q || !accept;

  tcw_front u_front (
    .clk_i, .rst_ni,
    .start_i(start && !busy),
    .op_i, .char_code_i, .cell_index_i,
    .accept_o(accept),
    .pop_i(pop),
    .cmd_valid_o(cmd_valid),
    .cmd_o(cmd)
  );

  tcw_back #(.Columns(Columns), .Rows(Rows)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid),
    .cmd_i(cmd),
    .pop_o(pop),
    .idle_o(idle),
    .text_cell_i({text_bg_q, text_fg_q, cmd.code}),
    .blank_cell_i({blank_bg_q, blank_fg_q, blank_code_q}),
    .done_o(done_o),
    .cursor_col_o, .cursor_row_o, .cursor_pos_o, .scrolled_o,
    .cell_code_o, .cell_fg_o, .cell_bg_o
  );
  logic unused;
  assign unused = idle;
endmodule
`default_nettype wire

/* tb/sv/tb_text_console_char_writer_top.sv */
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps
module tb_text_console_char_writer_top;
  localparam int Cols = 80;
  localparam int RowCount = 25;
  localparam int CellCount = Cols * RowCount;
  localparam int StallLimit = 20000;

  // Byte values that steer the cursor instead of being printed.
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChTab = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChReturn = 8'h0D;

  typedef struct packed {
    logic [6:0]  col;
    logic [4:0]  row;
    logic [10:0] pos;
    logic        scrolled;
    logic [7:0]  code;
    logic [3:0]  fg;
    logic [3:0]  bg;
  } cursor_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [7:0]  char_code_i;
  logic [10:0] cell_index_i;
  logic        done_o;
  logic [6:0]  cursor_col_o;
  logic [4:0]  cursor_row_o;
  logic [10:0] cursor_pos_o;
  logic        scrolled_o;
  logic [7:0]  cell_code_o;
  logic [3:0]  cell_fg_o;
  logic [3:0]  cell_bg_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  text_console_char_writer_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .done_o      (done_o),
    .cursor_col_o(cursor_col_o),
    .cursor_row_o(cursor_row_o),
    .cursor_pos_o(cursor_pos_o),
    .scrolled_o  (scrolled_o),
    .cell_code_o (cell_code_o),
    .cell_fg_o   (cell_fg_o),
    .cell_bg_o   (cell_bg_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Shadow copy of the screen, the cursor and the color registers.
  logic [15:0]  screen_shadow [CellCount];
  int           cur_col_q;
  int           cur_row_q;
  logic [3:0]   text_fg_q, text_bg_q, blank_fg_q, blank_bg_q;
  logic [7:0]   blank_code_q;
  cursor_beat_t pending_cursor_q[$];
  int           mismatch_count;
  int           idle_cycles;
  int           burst_left;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic logic [15:0] blank_cell();
    return {blank_bg_q, blank_fg_q, blank_code_q};
  endfunction

  // Computes the cursor beat that one command produces and updates the shadow.
  function automatic cursor_beat_t console_step(tcw_pkg::op_e op, logic [7:0] ch,
                                                logic [10:0] idx);
    cursor_beat_t r;
    r = '0;
    if (op == tcw_pkg::OP_PUT) begin
      if (ch == ChBackspace) begin
        if (cur_col_q > 0) cur_col_q--;
      end else if (ch == ChTab) begin
        cur_col_q = (cur_col_q + 8) & ~7;
      end else if (ch == ChNewline) begin
        cur_row_q++;
        cur_col_q = 0;
      end else if (ch == ChReturn) begin
        cur_col_q = 0;
      end else if (ch >= 8'h20 && ch <= 8'h7F) begin
        screen_shadow[cur_row_q * Cols + cur_col_q] = {text_bg_q, text_fg_q, ch};
        cur_col_q++;
      end
      if (cur_col_q >= Cols) begin
        cur_col_q = 0;
        cur_row_q++;
      end
      if (cur_row_q >= RowCount) begin
        // The screen moves up one line and a blank line enters at the bottom.
        for (int i = 0; i < CellCount - Cols; i++) screen_shadow[i] = screen_shadow[i + Cols];
        for (int i = CellCount - Cols; i < CellCount; i++) screen_shadow[i] = blank_cell();
        cur_row_q = RowCount - 1;
        r.scrolled = 1'b1;
      end
    end else if (op == tcw_pkg::OP_CLEAR) begin
      for (int i = 0; i < CellCount; i++) screen_shadow[i] = blank_cell();
      cur_col_q = 0;
      cur_row_q = 0;
    end else if (op == tcw_pkg::OP_READ && idx < CellCount) begin
      {r.bg, r.fg, r.code} = screen_shadow[idx];
    end
    r.col = cur_col_q[6:0];
    r.row = cur_row_q[4:0];
    r.pos = 11'(cur_row_q * Cols + cur_col_q);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Every done beat is checked against the oldest predicted cursor beat.
  always @(posedge clk_i) begin
    cursor_beat_t want;
    if (rst_ni && done_o) begin
      if (pending_cursor_q.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = pending_cursor_q.pop_front();
        if (cursor_col_o !== want.col) report_mismatch("cursor_col", cursor_col_o, want.col);
        if (cursor_row_o !== want.row) report_mismatch("cursor_row", cursor_row_o, want.row);
        if (cursor_pos_o !== want.pos) report_mismatch("cursor_pos", cursor_pos_o, want.pos);
        if (scrolled_o !== want.scrolled) report_mismatch("scrolled", scrolled_o, want.scrolled);
        if (cell_code_o !== want.code) report_mismatch("cell_code", cell_code_o, want.code);
        if (cell_fg_o !== want.fg) report_mismatch("cell_fg", cell_fg_o, want.fg);
        if (cell_bg_o !== want.bg) report_mismatch("cell_bg", cell_bg_o, want.bg);
      end
    end
  end

  // Watchdog: any long stretch without a beat on either side ends the run.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Sends one command beat. Start stays high across a burst and drops for a
  // random gap once the burst is used up.
  task automatic send_command(tcw_pkg::op_e op, logic [7:0] ch, logic [10:0] idx);
    cursor_beat_t r;
    start <= 1'b1;
    op_i <= op;
    char_code_i <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (busy);
    r = console_step(op, ch, idx);
    pending_cursor_q.push_back(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 20));
    end
  endtask

  // Waits until every predicted beat has arrived, then lets the block settle.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_cursor_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_register(logic [2:0] reg_idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_idx)
      tcw_pkg::RegTextFg: text_fg_q = value[3:0];
      tcw_pkg::RegTextBg: text_bg_q = value[3:0];
      tcw_pkg::RegBlankCode: blank_code_q = value[7:0];
      tcw_pkg::RegBlankFg: blank_fg_q = value[3:0];
      tcw_pkg::RegBlankBg: blank_bg_q = value[3:0];
      default: ;
    endcase
  endtask

  task automatic set_colors(logic [3:0] tfg, logic [3:0] tbg, logic [7:0] bcode,
                            logic [3:0] bfg, logic [3:0] bbg);
    drain_results();
    write_register(tcw_pkg::RegTextFg, {28'h0, tfg});
    write_register(tcw_pkg::RegTextBg, {28'h0, tbg});
    write_register(tcw_pkg::RegBlankCode, {24'h0, bcode});
    write_register(tcw_pkg::RegBlankFg, {28'h0, bfg});
    write_register(tcw_pkg::RegBlankBg, {28'h0, bbg});
  endtask

  // The store reads as zero after reset, and out-of-range reads give zero.
  task automatic test_reset_contents();
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'(CellCount - 1));
    send_command(tcw_pkg::OP_READ, 8'h00, 11'(CellCount));
    send_command(tcw_pkg::OP_READ, 8'h00, 11'h7FF);
  endtask

  // Printable extremes, ignored bytes and the unused operation.
  task automatic test_print_and_ignore();
    send_command(tcw_pkg::OP_PUT, 8'h20, '0);
    send_command(tcw_pkg::OP_PUT, 8'h7F, '0);
    send_command(tcw_pkg::OP_PUT, 8'h1F, '0);
    send_command(tcw_pkg::OP_PUT, 8'h80, '0);
    send_command(tcw_pkg::OP_PUT, 8'hFF, '0);
    send_command(tcw_pkg::OP_PUT, 8'h00, '0);
    send_command(tcw_pkg::OP_NONE, 8'h41, 11'd1);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd1);
  endtask

  // Backspace at column zero, tab stops, carriage return and the tab wrap.
  task automatic test_cursor_controls();
    send_command(tcw_pkg::OP_PUT, ChReturn, '0);
    send_command(tcw_pkg::OP_PUT, ChBackspace, '0);
    send_command(tcw_pkg::OP_PUT, ChTab, '0);
    send_command(tcw_pkg::OP_PUT, 8'h5A, '0);
    send_command(tcw_pkg::OP_PUT, ChBackspace, '0);
    for (int i = 0; i < 10; i++) send_command(tcw_pkg::OP_PUT, ChTab, '0);
  endtask

  // Newlines down to the last row force a scroll; the freshly blanked row and
  // the moved text are read back.
  task automatic test_scroll();
    send_command(tcw_pkg::OP_PUT, 8'h51, '0);
    for (int i = 0; i < RowCount; i++) send_command(tcw_pkg::OP_PUT, ChNewline, '0);
    for (int i = 0; i < 78; i++) send_command(tcw_pkg::OP_PUT, 8'h61, '0);
    send_command(tcw_pkg::OP_PUT, 8'h62, '0);
    send_command(tcw_pkg::OP_PUT, 8'h63, '0);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'(CellCount - 1));
    send_command(tcw_pkg::OP_READ, 8'h00, 11'(CellCount - Cols - 1));
  endtask

  task automatic test_clear();
    send_command(tcw_pkg::OP_CLEAR, '0, '0);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'd0);
    send_command(tcw_pkg::OP_READ, 8'h00, 11'(CellCount - 1));
  endtask

  // Random traffic: mostly printable text with occasional control bytes, reads
  // all over the store and rare clears, under changing color settings.
  task automatic test_random_traffic(int count);
    int pick;
    logic [7:0] ch;
    for (int n = 0; n < count; n++) begin
      if (n % 250 == 249)
        set_colors(4'($urandom), 4'($urandom), 8'($urandom), 4'($urandom), 4'($urandom));
      pick = int'($urandom_range(0, 99));
      if (pick < 60) begin
        ch = 8'($urandom_range(8'h20, 8'h7F));
        send_command(tcw_pkg::OP_PUT, ch, 11'($urandom));
      end else if (pick < 68) begin
        case ($urandom_range(0, 3))
          0: ch = ChBackspace;
          1: ch = ChTab;
          2: ch = ChNewline;
          default: ch = ChReturn;
        endcase
        send_command(tcw_pkg::OP_PUT, ch, 11'($urandom));
      end else if (pick < 72) begin
        ch = 8'($urandom);
        send_command(tcw_pkg::OP_PUT, ch, 11'($urandom));
      end else if (pick < 96) begin
        send_command(tcw_pkg::OP_READ, 8'($urandom), ($urandom_range(0, 19) == 0) ?
                     11'($urandom) : 11'($urandom_range(0, CellCount - 1)));
      end else if (pick < 98) begin
        send_command(tcw_pkg::OP_CLEAR, 8'($urandom), 11'($urandom));
      end else begin
        send_command(tcw_pkg::OP_NONE, 8'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    start <= 1'b0;
    op_i <= tcw_pkg::OP_PUT;
    char_code_i <= '0;
    cell_index_i <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst_ni <= 1'b0;
    for (int i = 0; i < CellCount; i++) screen_shadow[i] = '0;
    cur_col_q = 0;
    cur_row_q = 0;
    text_fg_q = 4'd15;
    text_bg_q = 4'd0;
    blank_code_q = 8'd32;
    blank_fg_q = 4'd15;
    blank_bg_q = 4'd0;
    mismatch_count = 0;
    idle_cycles = 0;
    burst_left = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_print_and_ignore();
    test_cursor_controls();
    set_colors(4'd0, 4'd15, 8'hFF, 4'd0, 4'd15);
    test_scroll();
    test_clear();
    set_colors(4'd15, 4'd15, 8'h00, 4'd15, 4'd15);
    test_clear();
    set_colors(4'd0, 4'd0, 8'hA5, 4'd0, 4'd0);
    test_random_traffic(1610);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
